/* hw/rtl/ralu_pkg.sv */
// Shared types, constants and codes of the RV32 ALU execute unit.
`default_nettype none
package ralu_pkg;

  localparam int XLEN                = 32;
  localparam int REG_COUNT           = 32;
  localparam int REG_IDX_W           = 5;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ILLEGAL     = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_MUL = 4'd2;
  localparam logic [3:0] ALU_SLL = 4'd3;
  localparam logic [3:0] ALU_SLT = 4'd4;
  localparam logic [3:0] ALU_XOR = 4'd5;
  localparam logic [3:0] ALU_SRL = 4'd6;
  localparam logic [3:0] ALU_SRA = 4'd7;
  localparam logic [3:0] ALU_OR  = 4'd8;
  localparam logic [3:0] ALU_AND = 4'd9;

  localparam logic [4:0] SHAMT_MASK = 5'h1F;

  typedef struct packed {
    logic [1:0]           status;
    logic [3:0]           alu_op;
    logic                 use_imm;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [XLEN-1:0]      imm;
  } decoded_t;

endpackage
`default_nettype wire

/* hw/rtl/ralu_if.sv */
// Request and result channel interfaces of the RV32 ALU execute unit.
`default_nettype none
interface ralu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface ralu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        wrote_reg;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic [31:0] next_pc;

  modport source (output valid, output status, output wrote_reg, output dest_index,
                  output dest_value, output next_pc, input ready);
  modport sink (input valid, input status, input wrote_reg, input dest_index,
                input dest_value, input next_pc, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ralu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ralu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ralu_front.sv */
// Front end: accepts instruction requests and decodes them into queue entries.
`default_nettype none
module ralu_front (
  ralu_in_if.sink               instr,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output ralu_pkg::decoded_t    push_item
);
  import ralu_pkg::*;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] w;

  assign w   = instr.instr_word;
  assign opc = w[6:0];
  assign f3  = w[14:12];
  assign f7  = w[31:25];

  assign push_valid  = instr.valid;
  assign instr.ready = push_ready;

  always_comb begin
    push_item.status  = STATUS_OK;
    push_item.alu_op  = ALU_ADD;
    push_item.use_imm = 1'b0;
    push_item.rd      = w[11:7];
    push_item.rs1     = w[19:15];
    push_item.rs2     = w[24:20];
    push_item.imm     = {{(XLEN-12){w[31]}}, w[31:20]};
    if (opc == OPC_OP) begin
      if (f3 != F3_ADD) begin
        push_item.status = STATUS_ILLEGAL;
      end else if (f7 == F7_BASE) begin
        push_item.alu_op = ALU_ADD;
      end else if (f7 == F7_MULDIV) begin
        push_item.alu_op = ALU_MUL;
      end else if (f7 == F7_ALT) begin
        push_item.alu_op = ALU_SUB;
      end else begin
        push_item.status = STATUS_ILLEGAL;
      end
    end else if (opc == OPC_OP_IMM) begin
      push_item.use_imm = 1'b1;
      case (f3)
        F3_ADD: push_item.alu_op = ALU_ADD;
        F3_SLL: begin
          if (f7 == F7_BASE) begin
            push_item.alu_op = ALU_SLL;
          end else begin
            push_item.status = STATUS_ILLEGAL;
          end
        end
        F3_SLT: push_item.alu_op = ALU_SLT;
        F3_XOR: push_item.alu_op = ALU_XOR;
        F3_SR: begin
          if (f7 == F7_BASE) begin
            push_item.alu_op = ALU_SRL;
          end else if (f7 == F7_ALT) begin
            push_item.alu_op = ALU_SRA;
          end else begin
            push_item.status = STATUS_ILLEGAL;
          end
        end
        F3_OR:   push_item.alu_op = ALU_OR;
        F3_AND:  push_item.alu_op = ALU_AND;
        F3_SLTU: push_item.status = STATUS_ILLEGAL;
        default: push_item.status = STATUS_ILLEGAL;
      endcase
    end else if (opc == OPC_LOAD || opc == OPC_STORE || opc == OPC_LUI ||
                 opc == OPC_BRANCH || opc == OPC_JAL || opc == OPC_SYSTEM) begin
      push_item.status = STATUS_UNSUPPORTED;
    end else begin
      push_item.status = STATUS_ILLEGAL;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ralu_queue.sv */
// Decoded-instruction queue between the front and back ends.
`default_nettype none
module ralu_queue #(
  parameter int DEPTH = ralu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire ralu_pkg::decoded_t push_item,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output ralu_pkg::decoded_t    pop_item
);
  import ralu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  decoded_t         slots [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[head];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + 1'b1;
      end
      if (do_pop) begin
        head <= (head == LAST_SLOT) ? '0 : head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk) disable iff (rst)
                   (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  assert property (@(posedge clk) disable iff (rst)
                   (count == '0) |-> (head == tail))
    else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

/* hw/rtl/ralu_back.sv */
// Back end: register read, execute, write-back, program counter and result register.
`default_nettype none
module ralu_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire ralu_pkg::decoded_t pop_item,
  ralu_out_if.source            result
);
  import ralu_pkg::*;

  logic                  e_valid;
  decoded_t              e_item;
  logic [REG_COUNT-1:0]  reg_valid;
  logic                  fwd_en;
  logic [REG_IDX_W-1:0]  fwd_idx;
  logic [XLEN-1:0]       fwd_val;
  logic [XLEN-1:0]       pc;
  logic [XLEN-1:0]       rdata_a;
  logic [XLEN-1:0]       rdata_b;
  logic [XLEN-1:0]       op_a;
  logic [XLEN-1:0]       reg_b;
  logic [XLEN-1:0]       op_b;
  logic [XLEN-1:0]       alu_val;
  logic [4:0]            shamt;
  logic                  fire;
  logic                  do_pop;
  logic                  ok;
  logic                  wr_en;
  logic [XLEN-1:0]       pc_next;

  assign fire      = e_valid && (!result.valid || result.ready);
  assign pop_ready = !e_valid || fire;
  assign do_pop    = pop_valid && pop_ready;
  assign ok        = (e_item.status == STATUS_OK);
  assign wr_en     = fire && ok && (e_item.rd != '0);
  assign pc_next   = ok ? pc + XLEN'(4) : pc;

  ralu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (e_item.rd),
    .wdata (alu_val),
    .re    (do_pop),
    .raddr (pop_item.rs1),
    .rdata (rdata_a)
  );

  ralu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (e_item.rd),
    .wdata (alu_val),
    .re    (do_pop),
    .raddr (pop_item.rs2),
    .rdata (rdata_b)
  );

  always_comb begin
    if (e_item.rs1 == '0) begin
      op_a = '0;
    end else if (fwd_en && fwd_idx == e_item.rs1) begin
      op_a = fwd_val;
    end else if (!reg_valid[e_item.rs1]) begin
      op_a = '0;
    end else begin
      op_a = rdata_a;
    end
    if (e_item.rs2 == '0) begin
      reg_b = '0;
    end else if (fwd_en && fwd_idx == e_item.rs2) begin
      reg_b = fwd_val;
    end else if (!reg_valid[e_item.rs2]) begin
      reg_b = '0;
    end else begin
      reg_b = rdata_b;
    end
    op_b  = e_item.use_imm ? e_item.imm : reg_b;
    shamt = op_b[4:0] & SHAMT_MASK;
  end

  always_comb begin
    case (e_item.alu_op)
      ALU_ADD: alu_val = op_a + op_b;
      ALU_SUB: alu_val = op_a - op_b;
      ALU_MUL: alu_val = XLEN'(op_a * op_b);
      ALU_SLL: alu_val = op_a << shamt;
      ALU_SLT: alu_val = ($signed(op_a) < $signed(op_b)) ? XLEN'(1) : '0;
      ALU_XOR: alu_val = op_a ^ op_b;
      ALU_SRL: alu_val = op_a >> shamt;
      ALU_SRA: alu_val = XLEN'($signed(op_a) >>> shamt);
      ALU_OR:  alu_val = op_a | op_b;
      ALU_AND: alu_val = op_a & op_b;
      default: alu_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      e_item <= pop_item;
    end
    if (wr_en) begin
      fwd_idx <= e_item.rd;
      fwd_val <= alu_val;
    end
    if (fire) begin
      result.status     <= e_item.status;
      result.wrote_reg  <= wr_en;
      result.dest_index <= wr_en ? e_item.rd : '0;
      result.dest_value <= wr_en ? alu_val : '0;
      result.next_pc    <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid      <= 1'b0;
      reg_valid    <= '0;
      fwd_en       <= 1'b0;
      pc           <= '0;
      result.valid <= 1'b0;
    end else begin
      if (pop_ready) begin
        e_valid <= pop_valid;
      end
      if (wr_en) begin
        reg_valid[e_item.rd] <= 1'b1;
        fwd_en               <= 1'b1;
      end
      if (fire) begin
        pc           <= pc_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) wr_en |-> e_item.rd != '0)
    else $error("write to x0");
  assert property (@(posedge clk) disable iff (rst)
                   (fire && ok) |=> pc == $past(pc) + XLEN'(4))
    else $error("pc did not advance");
  assert property (@(posedge clk) disable iff (rst)
                   (fire && !ok) |=> $stable(pc))
    else $error("pc moved on a rejected request");
  assert property (@(posedge clk) disable iff (rst)
                   (result.valid && result.wrote_reg) |-> result.status == STATUS_OK)
    else $error("write reported with bad status");

endmodule
`default_nettype wire

/* hw/rtl/rv32_alu_execute_unit.sv */
// Top level of the RV32 ALU execute unit.
// Channel instr (sink) takes one 32-bit RISC-V instruction word per request;
// channel result (source) returns one result per request, in order: status,
// wrote_reg, dest_index, dest_value and next_pc. Both use valid/ready; a
// request moves at a rising edge with valid and ready high.
// Supported: add, sub, mul (low word), addi, slli, slti, xori, srli, srai,
// ori, andi. x0 reads as zero and is never written. Other opcodes report
// illegal or unsupported, write nothing and hold the PC.
// Throughput is one request per cycle while the receiver does not stall the
// result channel. On an empty pipe the decoded request enters the queue at
// acceptance, then moves into execute as the register file is read (registered
// RAM read port), and from execute it loads the result register.
// Writes from one instruction are forwarded to the next, so dependent
// instructions also run back to back.
// Reset clears the queue, the pipeline, the PC and the register valid bits,
// so every register reads zero afterwards.
// When the receiver stalls, the result register holds, execute holds, and
// the queue absorbs up to QUEUE_DEPTH requests before instr.ready drops.
`default_nettype none
module rv32_alu_execute_unit #(
  parameter int QUEUE_DEPTH = ralu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ralu_in_if.sink     instr,
  ralu_out_if.source  result
);
  import ralu_pkg::*;

  logic     push_valid;
  logic     push_ready;
  decoded_t push_item;
  logic     pop_valid;
  logic     pop_ready;
  decoded_t pop_item;

  ralu_front u_front (
    .instr      (instr),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ralu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ralu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .result    (result)
  );

endmodule
`default_nettype wire

/* verif/rv32_alu_execute_unit_checker.sv */
// Checker of the RV32 ALU execute unit: predicts each result and compares it.
`timescale 1ns / 1ps
module rv32_alu_execute_unit_checker (
  input  logic clk,
  input  logic rst,
  ralu_in_if   instr_mon,
  ralu_out_if  result_mon,
  output int   fail_count,
  output int   pending_count
);
  import ralu_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic        wrote_reg;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] next_pc;
  } retire_t;

  logic [31:0] gpr [REG_COUNT];
  logic [31:0] pc;
  retire_t     pending_retires [$];
  retire_t     oldest;
  int          mismatches = 0;
  int          pending = 0;

  assign fail_count    = mismatches;
  assign pending_count = pending;

  function automatic retire_t retire_instr(input logic [31:0] word);
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  shamt;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] val;
    logic [1:0]  st;
    retire_t     r;
    opc   = word[6:0];
    rd    = word[11:7];
    f3    = word[14:12];
    rs1   = word[19:15];
    rs2   = word[24:20];
    f7    = word[31:25];
    shamt = word[24:20] & SHAMT_MASK;
    imm   = {{20{word[31]}}, word[31:20]};
    a     = (rs1 == 5'd0) ? 32'd0 : gpr[rs1];
    b     = (rs2 == 5'd0) ? 32'd0 : gpr[rs2];
    st    = STATUS_OK;
    val   = 32'd0;
    case (opc)
      OPC_OP: begin
        if (f3 != F3_ADD) begin
          st = STATUS_ILLEGAL;
        end else begin
          case (f7)
            F7_BASE:   val = a + b;
            F7_MULDIV: val = a * b;
            F7_ALT:    val = a - b;
            default:   st = STATUS_ILLEGAL;
          endcase
        end
      end
      OPC_OP_IMM: begin
        case (f3)
          F3_ADD: val = a + imm;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << shamt;
            else st = STATUS_ILLEGAL;
          end
          F3_SLT: val = {31'd0, $signed(a) < $signed(imm)};
          F3_XOR: val = a ^ imm;
          F3_SR: begin
            if (f7 == F7_BASE) val = a >> shamt;
            else if (f7 == F7_ALT) val = 32'($signed(a) >>> shamt);
            else st = STATUS_ILLEGAL;
          end
          F3_OR:  val = a | imm;
          F3_AND: val = a & imm;
          default: st = STATUS_ILLEGAL;
        endcase
      end
      OPC_LOAD, OPC_STORE, OPC_LUI, OPC_BRANCH, OPC_JAL, OPC_SYSTEM: st = STATUS_UNSUPPORTED;
      default: st = STATUS_ILLEGAL;
    endcase
    r = '0;
    r.status = st;
    if (st == STATUS_OK) begin
      pc = pc + 32'd4;
      if (rd != 5'd0) begin
        gpr[rd]      = val;
        r.wrote_reg  = 1'b1;
        r.dest_index = rd;
        r.dest_value = val;
      end
    end
    r.next_pc = pc;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = 32'd0;
      pc = 32'd0;
      pending_retires.delete();
    end else begin
      if (instr_mon.valid && instr_mon.ready) begin
        pending_retires.push_back(retire_instr(instr_mon.instr_word));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (pending_retires.size() == 0) begin
          $display("%0t: result with no request outstanding: status %0d next_pc 0x%08h",
                   $time, result_mon.status, result_mon.next_pc);
          mismatches++;
        end else begin
          oldest = pending_retires.pop_front();
          compare_field("status", 32'(oldest.status), 32'(result_mon.status));
          compare_field("wrote_reg", 32'(oldest.wrote_reg), 32'(result_mon.wrote_reg));
          compare_field("dest_index", 32'(oldest.dest_index), 32'(result_mon.dest_index));
          compare_field("dest_value", oldest.dest_value, result_mon.dest_value);
          compare_field("next_pc", oldest.next_pc, result_mon.next_pc);
        end
      end
    end
    pending = pending_retires.size();
  end

endmodule

/* verif/rv32_alu_execute_unit_tb.sv */
// Testbench top of the RV32 ALU execute unit: clock, reset, requests and verdict.
`timescale 1ns / 1ps
module rv32_alu_execute_unit_tb;
  import ralu_pkg::*;

  localparam int RANDOM_PER_PHASE = 425;
  localparam int HOLDOFF_CYCLES   = 80;
  localparam int DRAIN_CYCLES     = 10;
  localparam int TIMEOUT_NS       = 5_000_000;

  localparam logic [6:0] STUB_OPS [6] = '{OPC_LOAD, OPC_STORE, OPC_LUI,
                                         OPC_BRANCH, OPC_JAL, OPC_SYSTEM};
  localparam logic [2:0] IMM_F3S [7] = '{F3_ADD, F3_SLL, F3_SLT, F3_XOR,
                                        F3_SR, F3_OR, F3_AND};
  localparam logic [6:0] R_F7S [3] = '{F7_BASE, F7_MULDIV, F7_ALT};

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct = 8;
  int   recv_idle_pct = 71;
  logic holdoff_req = 1'b0;
  logic receiver_hold;

  ralu_in_if  instr_ch ();
  ralu_out_if result_ch ();

  rv32_alu_execute_unit uut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  rv32_alu_execute_unit_checker retire_check (
    .clk           (clk),
    .rst           (rst),
    .instr_mon     (instr_ch),
    .result_mon    (result_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd);
    return {imm, rs1, f3, rd, OPC_OP_IMM};
  endfunction

  function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] random_instr();
    int          pick;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    pick = $urandom_range(99);
    rd   = 5'($urandom);
    rs1  = 5'($urandom);
    rs2  = 5'($urandom);
    imm  = 12'($urandom);
    if (pick < 50) begin
      f3 = IMM_F3S[$urandom_range(6)];
      if (f3 == F3_SLL) imm[11:5] = F7_BASE;
      else if (f3 == F3_SR) imm[11:5] = ($urandom_range(1) != 0) ? F7_ALT : F7_BASE;
      return i_type(imm, rs1, f3, rd);
    end
    if (pick < 80) return r_type(R_F7S[$urandom_range(2)], rs2, rs1, F3_ADD, rd);
    if (pick < 88) begin
      case ($urandom_range(3))
        0: return r_type(7'($urandom), rs2, rs1, 3'($urandom), rd);
        1: return i_type(imm, rs1, F3_SLTU, rd);
        2: return i_type(imm, rs1, F3_SLL, rd);
        default: return i_type(imm, rs1, F3_SR, rd);
      endcase
    end
    if (pick < 94) return {25'($urandom), STUB_OPS[$urandom_range(5)]};
    return $urandom;
  endfunction

  task automatic issue_instr(input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    instr_ch.valid      <= 1'b1;
    instr_ch.instr_word <= word;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= !receiver_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    receiver_hold = 1'b0;
    wait (holdoff_req);
    @(negedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(negedge clk);
    receiver_hold <= 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("rv32_alu_execute_unit_tb: FAIL");
    $finish;
  end

  initial begin
    logic [31:0] directed_words [$];
    rst                 = 1'b1;
    instr_ch.valid      = 1'b0;
    instr_ch.instr_word = 32'd0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_words.push_back(i_type(12'hFFF, 5'd0, F3_ADD, 5'd1));
    directed_words.push_back(i_type(12'h7FF, 5'd0, F3_ADD, 5'd2));
    directed_words.push_back(i_type({F7_BASE, 5'd31}, 5'd1, F3_SLL, 5'd3));
    directed_words.push_back(i_type({F7_ALT, 5'd31}, 5'd3, F3_SR, 5'd4));
    directed_words.push_back(i_type({F7_BASE, 5'd31}, 5'd3, F3_SR, 5'd5));
    directed_words.push_back(r_type(F7_BASE, 5'd1, 5'd3, F3_ADD, 5'd6));
    directed_words.push_back(r_type(F7_ALT, 5'd3, 5'd0, F3_ADD, 5'd7));
    directed_words.push_back(r_type(F7_MULDIV, 5'd1, 5'd1, F3_ADD, 5'd8));
    directed_words.push_back(i_type(12'h7FF, 5'd3, F3_SLT, 5'd10));
    directed_words.push_back(i_type(12'hFFF, 5'd2, F3_XOR, 5'd12));
    directed_words.push_back(i_type(12'h555, 5'd3, F3_OR, 5'd13));
    directed_words.push_back(i_type(12'h800, 5'd1, F3_AND, 5'd14));
    directed_words.push_back(r_type(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0));
    foreach (STUB_OPS[i]) directed_words.push_back({25'h1FFFFFF, STUB_OPS[i]});
    directed_words.push_back(32'hFFFF_FFFF);
    directed_words.push_back(r_type(F7_BASE, 5'd2, 5'd1, F3_XOR, 5'd20));
    directed_words.push_back(r_type(7'h7F, 5'd2, 5'd1, F3_ADD, 5'd20));
    directed_words.push_back(i_type(12'h001, 5'd1, F3_SLTU, 5'd20));
    directed_words.push_back(i_type({F7_ALT, 5'd3}, 5'd1, F3_SLL, 5'd20));
    directed_words.push_back(i_type({7'h10, 5'd3}, 5'd1, F3_SR, 5'd20));
    foreach (directed_words[i]) issue_instr(directed_words[i]);

    repeat (RANDOM_PER_PHASE) issue_instr(random_instr());

    send_idle_pct = 71;
    recv_idle_pct <= 8;
    repeat (RANDOM_PER_PHASE) issue_instr(random_instr());

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    holdoff_req   <= 1'b1;
    repeat (RANDOM_PER_PHASE) issue_instr(random_instr());
    instr_ch.valid <= 1'b0;

    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("rv32_alu_execute_unit_tb: PASS");
    end else begin
      $display("rv32_alu_execute_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
